>>> rtl/core/page_directory_write_invalidate_core_assert.svh
// Assertion macros shared by the page directory RTL.
`ifndef PAGE_DIRECTORY_WRITE_INVALIDATE_CORE_ASSERT_SVH
`define PAGE_DIRECTORY_WRITE_INVALIDATE_CORE_ASSERT_SVH

// Check a same-cycle implication on the clk/arst_n domain.
`define PDWI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle on the clk/arst_n domain.
`define PDWI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pdwi_pkg.sv
// Shared types and constants of the page directory.
package pdwi_pkg;

	localparam int NUM_CLIENTS = 16;
	localparam int NUM_PAGES   = 128;

	localparam int CLIENT_W = 4;
	localparam int PAGE_W   = 7;
	localparam int MASK_W   = 16;
	localparam int PAGE_AW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic [NUM_CLIENTS-1:0] sharer_t;
	typedef logic [PAGE_AW-1:0]     page_addr_t;

	typedef struct packed {
		logic                op;
		logic [CLIENT_W-1:0] client_id;
		logic [PAGE_W-1:0]   page_index;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [MASK_W-1:0]   invalidate_mask;
		logic                prev_owner_valid;
		logic [CLIENT_W-1:0] prev_owner;
		logic [CLIENT_W-1:0] new_owner;
	} rsp_t;

	// Classified request handed from front to back.
	typedef struct packed {
		logic                op;
		logic [CLIENT_W-1:0] client_id;
		page_addr_t          page;
		logic                page_ok;
		logic                client_ok;
	} cmd_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		ST_ISSUE = 2'b01,
		ST_EXEC  = 2'b10
	} back_state_t;

	// Status of the back end seen by the top level.
	typedef struct packed {
		logic        busy;
		back_state_t state;
	} back_stat_t;

endpackage

>>> rtl/core/pdwi_front.sv
// Front end: range-checks an incoming request word and forms a command.
module pdwi_front (
	input  pdwi_pkg::req_t req,
	input  logic           push,
	input  logic           cmdq_full,
	output logic           full,
	output logic           cmd_push,
	output pdwi_pkg::cmd_t cmd
);
	import pdwi_pkg::*;

	// Classify page and client against the directory size.
	always_comb begin
		cmd.op        = req.op;
		cmd.client_id = req.client_id;
		cmd.page      = PAGE_AW'(req.page_index);
		cmd.page_ok   = (int'(req.page_index) < NUM_PAGES);
		cmd.client_ok = (int'(req.client_id) < NUM_CLIENTS);
	end

	// Stall the requester while the command queue has no room.
	assign full     = cmdq_full;
	assign cmd_push = push && !cmdq_full;

endmodule

>>> rtl/core/pdwi_cmdq.sv
// Short command queue between front and back end.
module pdwi_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pdwi_pkg::cmd_t push_cmd,
	input  logic           pop,
	output pdwi_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);
	import pdwi_pkg::*;

	cmd_t                 entry_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]   wr_ptr_q;
	logic [CMDQ_AW-1:0]   rd_ptr_q;
	logic [CMDQ_CW-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	// Store a pushed word.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == CMDQ_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == CMDQ_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/pdwi_back.sv
// Back end: reads a directory entry, updates it and produces the result word.
module pdwi_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pdwi_pkg::cmd_t     cmd,
	input  logic               cmdq_empty,
	output logic               cmdq_pop,
	input  logic               pop,
	output logic               empty,
	output pdwi_pkg::rsp_t     rsp,
	output pdwi_pkg::back_stat_t stat
);
	import pdwi_pkg::*;

	// Directory storage; an entry counts only once its page flag is set.
	sharer_t             sharer_mem [NUM_PAGES];
	logic [CLIENT_W-1:0] owner_mem  [NUM_PAGES];
	logic [NUM_PAGES-1:0] page_vld_q;

	back_state_t         state_q;
	cmd_t                cmd_q;
	sharer_t             sharer_rd_q;
	logic [CLIENT_W-1:0] owner_rd_q;
	logic                vld_rd_q;
	rsp_t                out_q;
	logic                out_vld_q;

	sharer_t             held;
	sharer_t             me;
	sharer_t             new_held;
	logic [CLIENT_W-1:0] new_owner;
	logic                upd_en;
	logic                out_free;
	logic                finish;
	rsp_t                res;

	assign out_free = !out_vld_q || pop;
	assign cmdq_pop = (state_q == ST_ISSUE) && !cmdq_empty;
	assign finish   = (state_q == ST_EXEC) && out_free;
	assign empty    = !out_vld_q;
	assign rsp      = out_q;
	assign stat     = '{busy: (state_q == ST_EXEC) || out_vld_q, state: state_q};

	// Work out the result and the entry update for the fetched entry.
	always_comb begin
		held      = vld_rd_q ? sharer_rd_q : '0;
		me        = sharer_t'(1) << cmd_q.client_id;
		new_held  = held;
		new_owner = owner_rd_q;
		upd_en    = 1'b0;
		res       = '0;
		if (cmd_q.page_ok) begin
			res.prev_owner_valid = vld_rd_q;
			res.prev_owner       = vld_rd_q ? owner_rd_q : '0;
			res.new_owner        = res.prev_owner;
			if (cmd_q.client_ok) begin
				upd_en = 1'b1;
				if (cmd_q.op == OP_READ) begin
					if ((held & me) != '0) begin
						res.hit = 1'b1;
						upd_en  = 1'b0;
					end else begin
						if (held == '0 || !vld_rd_q) begin
							new_owner     = cmd_q.client_id;
							res.new_owner = cmd_q.client_id;
						end
						new_held = held | me;
					end
				end else begin
					res.invalidate_mask = MASK_W'(held & ~me);
					new_held            = me;
					new_owner           = cmd_q.client_id;
					res.new_owner       = cmd_q.client_id;
				end
			end
		end
	end

	// Fetch on issue, write back on finish.
	always_ff @(posedge clk) begin
		if (cmdq_pop) begin
			cmd_q       <= cmd;
			sharer_rd_q <= sharer_mem[cmd.page];
			owner_rd_q  <= owner_mem[cmd.page];
		end
		if (finish && upd_en) begin
			sharer_mem[cmd_q.page] <= new_held;
			owner_mem[cmd_q.page]  <= new_owner;
		end
		if (finish) begin
			out_q <= res;
		end
	end

	// Sequence issue and execute, hold the result word, track page flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ISSUE;
			out_vld_q  <= 1'b0;
			vld_rd_q   <= 1'b0;
			page_vld_q <= '0;
		end else begin
			unique case (state_q)
				ST_ISSUE: begin
					if (cmdq_pop) begin
						vld_rd_q <= page_vld_q[cmd.page];
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_ISSUE;
					end
				end
				default: begin
					state_q <= ST_ISSUE;
				end
			endcase
			if (finish && upd_en) begin
				page_vld_q[cmd_q.page] <= 1'b1;
			end
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/page_directory_write_invalidate_core.sv
// Page directory with write-invalidate coherence: top level.
//
// Requests come in through a queue-style port: a word (op, client_id,
// page_index) is taken at a clock edge with push high and full low.
// Results leave the same way: while empty is low the oldest result word
// (hit, invalidate_mask, prev_owner_valid, prev_owner, new_owner) sits on
// rsp and is taken at an edge with pop high.
// One result word comes out for every request, in request order.
// Between a request and its result lie the command queue, the back end's
// issue and execute states and the result register. The back end finishes
// one request, a read-then-write of its directory entry, before it issues
// the next; a two-word command queue lets the front keep taking requests meanwhile.
// When the receiver stalls, the result word holds, the back end waits with
// the next entry fetched, and full rises once the command queue fills.
// Reset empties both queues and clears the per-page flags, so every page
// reads as having no holder and no owner; no clearing pass is needed.
module page_directory_write_invalidate_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  pdwi_pkg::req_t req,
	output logic           empty,
	input  logic           pop,
	output pdwi_pkg::rsp_t rsp
);
	import pdwi_pkg::*;

	`include "page_directory_write_invalidate_core_assert.svh"

	cmd_t       fr_cmd;
	logic       fr_push;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	cmd_t       q_head;
	back_stat_t bk_stat;

	pdwi_front u_front (
		.req       (req),
		.push      (push),
		.cmdq_full (q_full),
		.full      (full),
		.cmd_push  (fr_push),
		.cmd       (fr_cmd)
	);

	pdwi_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fr_push),
		.push_cmd (fr_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	pdwi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (q_head),
		.cmdq_empty (q_empty),
		.cmdq_pop   (q_pop),
		.pop        (pop),
		.empty      (empty),
		.rsp        (rsp),
		.stat       (bk_stat)
	);

	// A hit is a read of a held page: it has an owner and drops nobody.
	`PDWI_ASSERT_NOW(a_hit_no_inval, !empty && rsp.hit,
		rsp.invalidate_mask == '0 && rsp.prev_owner_valid, "hit with invalidation or no owner")
	// No previous owner reports owner zero.
	`PDWI_ASSERT_NOW(a_no_owner_zero, !empty && !rsp.prev_owner_valid,
		rsp.prev_owner == '0, "prev_owner set without owner")
	// An accepted request leaves work queued or in the back end.
	`PDWI_ASSERT_NEXT(a_push_tracked, push && !full,
		!q_empty || bk_stat.busy, "accepted request lost")

endmodule
